// ===== rtl/core/json_string_unescape_utf8_assert.svh =====
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// shared types and status codes for the json string unescaper
package jsu_pkg;

	localparam int JSU_QUEUE_DEPTH = 4;

	// result status codes
	localparam logic [3:0] ST_BYTE     = 4'd0;
	localparam logic [3:0] ST_DONE     = 4'd1;
	localparam logic [3:0] ST_NO_QUOTE = 4'd2;
	localparam logic [3:0] ST_CONTROL  = 4'd3;
	localparam logic [3:0] ST_BAD_ESC  = 4'd4;
	localparam logic [3:0] ST_BAD_HEX  = 4'd5;
	localparam logic [3:0] ST_MISS_LOW = 4'd6;
	localparam logic [3:0] ST_BAD_LOW  = 4'd7;
	localparam logic [3:0] ST_LONE_LOW = 4'd8;
	localparam logic [3:0] ST_UNTERM   = 4'd9;
	localparam logic [3:0] ST_END_ESC  = 4'd10;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] status;
		logic       last;
	} out_t;

	// one decoded request: a code point (or raw byte), its utf-8 length - 1, a status
	typedef struct packed {
		logic [20:0] cp;
		logic [1:0]  cnt;
		logic [3:0]  status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/core/jsu_front.sv =====
// front end: escape and surrogate decoding, one input byte per cycle while the queue has room
module jsu_front import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	input  queue_stat_t q_stat,
	output logic        push,
	output job_t        push_job
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		S_WAIT, S_BODY, S_ESC, S_HEX1, S_NEED_BSL, S_NEED_U, S_HEX2
	} mode_t;

	mode_t       mode_q, mode_n;
	logic [1:0]  hex_cnt_q, hex_cnt_n;
	logic [15:0] hex_acc_q, hex_acc_n;
	logic [9:0]  hi_q, hi_n;
	logic        accept;
	logic        emit;
	job_t        job;
	logic [4:0]  hv;
	logic [15:0] quad;
	logic [7:0]  c;
	logic        e;

	// hex digit value, 16 for a non-hex byte
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b inside {[8'h30:8'h39]}) v = {1'b0, b[3:0]};
		else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) v = {1'b0, b[3:0] + 4'd9};
		else v = 5'd16;
		return v;
	endfunction

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign c        = in_data.in_byte;
	assign e        = in_data.end_of_input;
	assign hv       = hex_value(c);
	assign quad     = {hex_acc_q[11:0], hv[3:0]};

	always_comb begin
		mode_n    = mode_q;
		hex_cnt_n = hex_cnt_q;
		hex_acc_n = hex_acc_q;
		hi_n      = hi_q;
		emit      = 1'b0;
		job       = '0;

		case (mode_q)
			S_BODY: begin
				if (e) begin
					emit = 1'b1; job.status = ST_UNTERM;
				end else if (c == CH_QUOTE) begin
					emit = 1'b1; job.status = ST_DONE; mode_n = S_WAIT;
				end else if (c < CH_SPACE) begin
					emit = 1'b1; job.status = ST_CONTROL;
				end else if (c == CH_BSL) begin
					mode_n = S_ESC;
				end else begin
					emit = 1'b1; job.cp = {13'd0, c};
				end
			end
			S_ESC: begin
				mode_n = S_BODY;
				emit   = 1'b1;
				if (e) begin
					job.status = ST_END_ESC;
				end else begin
					case (c)
						CH_QUOTE, CH_BSL, CH_SLASH: job.cp = {13'd0, c};
						CH_B: job.cp = 21'h08;
						CH_F: job.cp = 21'h0C;
						CH_N: job.cp = 21'h0A;
						CH_R: job.cp = 21'h0D;
						CH_T: job.cp = 21'h09;
						CH_U: begin
							emit      = 1'b0;
							mode_n    = S_HEX1;
							hex_cnt_n = 2'd0;
							hex_acc_n = 16'd0;
						end
						default: job.status = ST_BAD_ESC;
					endcase
				end
			end
			S_HEX1, S_HEX2: begin
				if (e) begin
					emit = 1'b1; job.status = ST_END_ESC;
				end else if (hv[4]) begin
					emit = 1'b1; job.status = ST_BAD_HEX;
				end else if (hex_cnt_q != 2'd3) begin
					hex_cnt_n = hex_cnt_q + 2'd1;
					hex_acc_n = quad;
				end else begin
					hex_cnt_n = 2'd0;
					hex_acc_n = quad;
					if (mode_q == S_HEX1) begin
						if (quad inside {[16'hD800:16'hDBFF]}) begin
							hi_n   = quad[9:0];
							mode_n = S_NEED_BSL;
						end else if (quad inside {[16'hDC00:16'hDFFF]}) begin
							emit = 1'b1; job.status = ST_LONE_LOW;
						end else begin
							emit   = 1'b1;
							mode_n = S_BODY;
							job.cp = {5'd0, quad};
							if (quad <= 16'h007F) job.cnt = 2'd0;
							else if (quad <= 16'h07FF) job.cnt = 2'd1;
							else job.cnt = 2'd2;
						end
					end else begin
						emit = 1'b1;
						if (quad inside {[16'hDC00:16'hDFFF]}) begin
							mode_n  = S_BODY;
							job.cp  = 21'h10000 + {1'b0, hi_q, quad[9:0]};
							job.cnt = 2'd3;
						end else begin
							job.status = ST_BAD_LOW;
						end
					end
				end
			end
			S_NEED_BSL: begin
				if (e || c != CH_BSL) begin
					emit = 1'b1; job.status = ST_MISS_LOW;
				end else begin
					mode_n = S_NEED_U;
				end
			end
			S_NEED_U: begin
				if (e || c != CH_U) begin
					emit = 1'b1; job.status = ST_MISS_LOW;
				end else begin
					mode_n    = S_HEX2;
					hex_cnt_n = 2'd0;
					hex_acc_n = 16'd0;
				end
			end
			default: begin
				if (!e && c == CH_QUOTE) begin
					mode_n    = S_BODY;
					hex_cnt_n = 2'd0;
					hex_acc_n = 16'd0;
					hi_n      = 10'd0;
				end else begin
					emit = 1'b1; job.status = ST_NO_QUOTE;
				end
			end
		endcase

		// every error drops back to waiting with cleared counters
		if (emit && job.status != ST_BYTE && job.status != ST_DONE) begin
			mode_n    = S_WAIT;
			hex_cnt_n = 2'd0;
			hex_acc_n = 16'd0;
			hi_n      = 10'd0;
		end
	end

	assign push     = accept && emit;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= S_WAIT;
			hex_cnt_q <= 2'd0;
			hex_acc_q <= 16'd0;
			hi_q      <= 10'd0;
		end else if (accept) begin
			mode_q    <= mode_n;
			hex_cnt_q <= hex_cnt_n;
			hex_acc_q <= hex_acc_n;
			hi_q      <= hi_n;
		end
	end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// small request queue between front and back ends
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	input  logic        pop,
	output job_t        head_job,
	output queue_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head_job     = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== rtl/core/jsu_back.sv =====
// back end: utf-8 serialiser feeding the output register
module jsu_back import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t q_stat,
	input  job_t        head_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_t       out_q;
	logic       load;
	logic       fin;

	// byte k of the encoding; a one-byte request carries its byte as is
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] cnt,
		input logic [1:0] k);
		logic [7:0] b;
		case (cnt)
			2'd0: b = cp[7:0];
			2'd1: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			2'd2: begin
				case (k)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (k)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

	assign load      = !q_stat.empty && (!out_valid_q || out_ready);
	assign fin       = (idx_q == head_job.cnt);
	assign pop       = load && fin;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= utf8_byte(head_job.cp, head_job.cnt, idx_q);
			out_q.status   <= head_job.status;
			out_q.last     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// top level of the json string unescaper with utf-8 output
// bytes of a quoted json string enter one per request on the in channel, starting with
// the opening quote; each request yields zero to four result requests on the out channel,
// the final one flagged by last. the front end takes one byte every cycle whenever the
// request queue has room, and decodes escapes and surrogate pairs into at most one queued
// request per byte. the back end serialises each queued request at one result per cycle
// while out_ready is high; a byte that gives n utf-8 bytes yields n results (n is 1 to 4);
// sustained throughput is one input byte per cycle as long as out_ready stays high and the
// average output is at most one result per input. at the earliest a result reaches the
// output once its byte has passed the request queue and then the output register. the
// queue depth (QUEUE_DEPTH, 2 or more) sets how long a burst of multi-byte characters or an
// output stall can be absorbed before in_ready drops
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	// front to queue
	logic        push;
	job_t        push_job;
	// queue to back
	job_t        head_job;
	logic        pop;
	queue_stat_t q_stat;
	// shape of a status result
	logic        status_res;
	logic        status_ok;

	// escape, hex quad and surrogate decoding
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// decouples the byte-per-cycle front from the bursty serialiser
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	// utf-8 serialiser and output register
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status_res = out_valid && out_data.status != ST_BYTE;
	assign status_ok  = out_data.last && out_data.out_byte == 8'd0;

	// a status result carries no byte and closes its input byte
	`JSU_ASSERT_NOW(a_status_is_last, status_res, status_ok, "status result malformed")
	// the queue is never written while full nor read while empty
	`JSU_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
	`JSU_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
	// after a push the queue is not empty on the next cycle
	`JSU_ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "queue empty after push")

endmodule
